FILE: design/gmaf_pkg.sv
// ----------------------------------------------------------------------------
// gmaf_pkg
// Shared constants and types of the gated moving average filter.
// ----------------------------------------------------------------------------
package gmaf_pkg;

  localparam int unsigned DistW    = 16;
  localparam int unsigned ChanW    = 2;
  localparam int unsigned CfgIdxW  = 8;

  localparam logic [DistW-1:0] FillValue    = 16'd4000;
  localparam logic [DistW-1:0] InvalidReset = 16'hFFFF;

  localparam logic [CfgIdxW-1:0] CfgMaxDist = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgInvCode = 8'd1;

  typedef struct packed {
    logic             vld;
    logic [DistW-1:0] data;
  } ring_upd_t;

endpackage

FILE: design/gmaf_cfg.sv
// ----------------------------------------------------------------------------
// gmaf_cfg
// Configuration registers: maximum valid distance and invalid reading code.
// ----------------------------------------------------------------------------
module gmaf_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [gmaf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [gmaf_pkg::DistW-1:0]   cfg_data_i,
  output logic                         cfg_ready_o,
  output logic [gmaf_pkg::DistW-1:0]   max_distance_o,
  output logic [gmaf_pkg::DistW-1:0]   inv_code_o
);

  logic [gmaf_pkg::DistW-1:0] max_distance_q;
  logic [gmaf_pkg::DistW-1:0] inv_code_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_distance_q <= gmaf_pkg::FillValue;
      inv_code_q     <= gmaf_pkg::InvalidReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gmaf_pkg::CfgMaxDist: max_distance_q <= cfg_data_i;
        gmaf_pkg::CfgInvCode: inv_code_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign max_distance_o = max_distance_q;
  assign inv_code_o     = inv_code_q;

endmodule

FILE: design/gmaf_ring.sv
// ----------------------------------------------------------------------------
// gmaf_ring
// Per-channel ring of recent readings in one memory, with write positions
// and wrap flags; entries not yet written since reset read as the fill value.
// ----------------------------------------------------------------------------
module gmaf_ring #(
  parameter int unsigned WINDOW_SIZE   = 8,
  parameter int unsigned CHANNEL_COUNT = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_i,
  input  logic [gmaf_pkg::ChanW-1:0] req_ch_i,
  input  gmaf_pkg::ring_upd_t        upd_i,
  output logic [gmaf_pkg::DistW-1:0] old_o
);

  localparam int unsigned ChW   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int unsigned PosW  = $clog2(WINDOW_SIZE);
  localparam int unsigned Depth = CHANNEL_COUNT * WINDOW_SIZE;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [PosW-1:0] LastPos = PosW'(WINDOW_SIZE - 1);

  logic [PosW-1:0]            pos_q  [CHANNEL_COUNT];
  logic                       wrap_q [CHANNEL_COUNT];
  logic [gmaf_pkg::DistW-1:0] mem_q  [Depth];
  logic [gmaf_pkg::DistW-1:0] rd_q;
  logic [PosW-1:0]            rd_pos_q;
  logic [PosW-1:0]            rd_pos_d;
  logic [ChW-1:0]             rd_idx_q;
  logic [ChW-1:0]             req_idx;
  logic [PosW-1:0]            upd_nxt;
  logic [AddrW-1:0]           rd_addr;
  logic [AddrW-1:0]           wr_addr;

  assign req_idx = (int'(req_ch_i) < CHANNEL_COUNT) ? ChW'(req_ch_i) : '0;
  assign upd_nxt = (rd_pos_q == LastPos) ? '0 : rd_pos_q + 1'b1;

  // forward the position of the request that updates in this same cycle
  assign rd_pos_d = (upd_i.vld && (rd_idx_q == req_idx)) ? upd_nxt : pos_q[req_idx];

  assign rd_addr = AddrW'(int'(req_idx) * WINDOW_SIZE + int'(rd_pos_d));
  assign wr_addr = AddrW'(int'(rd_idx_q) * WINDOW_SIZE + int'(rd_pos_q));

  always_ff @(posedge clk_i) begin
    if (upd_i.vld) begin
      mem_q[wr_addr] <= upd_i.data;
    end
    if (req_i) begin
      rd_q     <= mem_q[rd_addr];
      rd_pos_q <= rd_pos_d;
      rd_idx_q <= req_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        pos_q[i]  <= '0;
        wrap_q[i] <= 1'b0;
      end
    end else if (upd_i.vld) begin
      pos_q[rd_idx_q] <= upd_nxt;
      if (rd_pos_q == LastPos) begin
        wrap_q[rd_idx_q] <= 1'b1;
      end
    end
  end

  assign old_o = wrap_q[rd_idx_q] ? rd_q : gmaf_pkg::FillValue;

endmodule

FILE: design/gmaf_acc.sv
// ----------------------------------------------------------------------------
// gmaf_acc
// Input register, validity gate, running sums and averages, result register.
// ----------------------------------------------------------------------------
module gmaf_acc #(
  parameter int unsigned WINDOW_SIZE   = 8,
  parameter int unsigned CHANNEL_COUNT = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_valid_i,
  output logic                       s_ready_o,
  input  logic [gmaf_pkg::ChanW-1:0] s_ch_i,
  input  logic [gmaf_pkg::DistW-1:0] s_distance_i,
  input  logic [gmaf_pkg::DistW-1:0] max_distance_i,
  input  logic [gmaf_pkg::DistW-1:0] inv_code_i,
  input  logic [gmaf_pkg::DistW-1:0] old_i,
  output gmaf_pkg::ring_upd_t        upd_o,
  input  logic                       m_ready_i,
  output logic                       m_valid_o,
  output logic [gmaf_pkg::ChanW-1:0] m_ch_o,
  output logic [gmaf_pkg::DistW-1:0] m_avg_o,
  output logic                       m_acc_o
);

  localparam int unsigned ChW  = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam int unsigned SumW = gmaf_pkg::DistW + $clog2(WINDOW_SIZE);
  localparam logic [SumW-1:0] SumReset = SumW'(int'(gmaf_pkg::FillValue) * WINDOW_SIZE);

  logic                       s1_vld_q;
  logic [gmaf_pkg::ChanW-1:0] s1_ch_q;
  logic [gmaf_pkg::DistW-1:0] s1_distance_q;
  logic                       out_vld_q;
  logic [gmaf_pkg::ChanW-1:0] out_ch_q;
  logic [gmaf_pkg::DistW-1:0] out_avg_q;
  logic                       out_acc_q;
  logic [SumW-1:0]            sum_q [CHANNEL_COUNT];
  logic [gmaf_pkg::DistW-1:0] avg_q [CHANNEL_COUNT];

  logic                       adv;
  logic                       ch_ok;
  logic                       samp_ok;
  logic                       upd;
  logic [ChW-1:0]             idx;
  logic [SumW-1:0]            sum_d;
  logic [gmaf_pkg::DistW-1:0] avg_d;
  logic [gmaf_pkg::DistW-1:0] res_avg;

  assign adv       = s1_vld_q && (!out_vld_q || m_ready_i);
  assign s_ready_o = !s1_vld_q || adv;

  assign ch_ok   = int'(s1_ch_q) < CHANNEL_COUNT;
  assign idx     = ch_ok ? ChW'(s1_ch_q) : '0;
  assign samp_ok = ch_ok && (s1_distance_q != inv_code_i) &&
                   (s1_distance_q <= max_distance_i);
  assign upd     = adv && samp_ok;

  assign sum_d   = sum_q[idx] - SumW'(old_i) + SumW'(s1_distance_q);
  assign avg_d   = gmaf_pkg::DistW'(sum_d / WINDOW_SIZE);
  assign res_avg = !ch_ok ? '0 : (samp_ok ? avg_d : avg_q[idx]);

  assign upd_o.vld  = upd;
  assign upd_o.data = s1_distance_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        sum_q[i] <= SumReset;
        avg_q[i] <= gmaf_pkg::FillValue;
      end
    end else begin
      if (s_ready_o) begin
        s1_vld_q <= s_valid_i;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (m_ready_i) begin
        out_vld_q <= 1'b0;
      end
      if (upd) begin
        sum_q[idx] <= sum_d;
        avg_q[idx] <= avg_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      s1_ch_q       <= s_ch_i;
      s1_distance_q <= s_distance_i;
    end
    if (adv) begin
      out_ch_q  <= s1_ch_q;
      out_avg_q <= res_avg;
      out_acc_q <= samp_ok;
    end
  end

  assign m_valid_o = out_vld_q;
  assign m_ch_o    = out_ch_q;
  assign m_avg_o   = out_avg_q;
  assign m_acc_o   = out_acc_q;

endmodule

FILE: design/gated_moving_average_filter.sv
// ----------------------------------------------------------------------------
// gated_moving_average_filter
// Multi-channel gated boxcar moving average for range sensor readings.
// ----------------------------------------------------------------------------
// Takes one reading request per cycle while the receiver does not stall the
// result register and returns one result per request through the input and
// result registers; the ring memory does one read and one write per cycle,
// with the write position forwarded between back-to-back requests of one channel.
// A reading enters its channel's window only if its channel is in range, it
// differs from the invalid code and it does not exceed the maximum distance;
// the result carries the channel's current average and the accept flag. Ring
// entries not yet written since reset read as 4000, so no clearing pass follows
// reset. Write the configuration registers only while no request is in flight.
module gated_moving_average_filter #(
  parameter int unsigned WINDOW_SIZE   = 8,
  parameter int unsigned CHANNEL_COUNT = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [23:0]                  s_axis_tdata,  // channel, distance, zero pad
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [23:0]                  m_axis_tdata,  // out_channel, filtered_distance, pad
  output logic                         m_axis_tuser,  // sample_accepted
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [gmaf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [gmaf_pkg::DistW-1:0]   cfg_data_i
);

  logic [gmaf_pkg::DistW-1:0] max_distance;
  logic [gmaf_pkg::DistW-1:0] inv_code;
  logic [gmaf_pkg::DistW-1:0] old_val;
  logic [gmaf_pkg::ChanW-1:0] m_ch;
  logic [gmaf_pkg::DistW-1:0] m_avg;
  logic                       req;
  gmaf_pkg::ring_upd_t        upd;

  assign req = s_axis_tvalid && s_axis_tready;

  gmaf_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cfg_ready_o    (cfg_ready_o),
    .max_distance_o (max_distance),
    .inv_code_o     (inv_code)
  );

  gmaf_ring #(
    .WINDOW_SIZE   (WINDOW_SIZE),
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .req_ch_i (s_axis_tdata[1:0]),
    .upd_i    (upd),
    .old_o    (old_val)
  );

  gmaf_acc #(
    .WINDOW_SIZE   (WINDOW_SIZE),
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_acc (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_valid_i      (s_axis_tvalid),
    .s_ready_o      (s_axis_tready),
    .s_ch_i         (s_axis_tdata[1:0]),
    .s_distance_i   (s_axis_tdata[17:2]),
    .max_distance_i (max_distance),
    .inv_code_i     (inv_code),
    .old_i          (old_val),
    .upd_o          (upd),
    .m_ready_i      (m_axis_tready),
    .m_valid_o      (m_axis_tvalid),
    .m_ch_o         (m_ch),
    .m_avg_o        (m_avg),
    .m_acc_o        (m_axis_tuser)
  );

  assign m_axis_tdata = {6'd0, m_avg, m_ch};

endmodule

FILE: verif/gated_moving_average_filter_tb.sv
// ----------------------------------------------------------------------------
// gated_moving_average_filter_tb
// Self-checking testbench of the gated moving average filter. A driver feeds
// readings from a queue and a monitor compares every result with the value
// predicted from a local copy of the rings, sums and limits. It runs directed
// edge cases, then random phases under several limit settings and several
// patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module gated_moving_average_filter_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TapCount    = 8;
  localparam int unsigned NumChannels = 4;
  localparam int unsigned PosW        = $clog2(TapCount);
  localparam int unsigned SumW        = 19;
  localparam int unsigned CycleLimit  = 200000;

  localparam logic [gmaf_pkg::CfgIdxW-1:0] CfgUnmapped = 8'd2;
  localparam logic [gmaf_pkg::CfgIdxW-1:0] CfgTopIndex = 8'hFF;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [gmaf_pkg::ChanW-1:0] channel;
    logic [gmaf_pkg::DistW-1:0] distance;
  } reading_t;

  typedef struct packed {
    logic [gmaf_pkg::ChanW-1:0] out_channel;
    logic [gmaf_pkg::DistW-1:0] average;
    logic                       accepted;
  } filter_result_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [23:0]                  s_axis_tdata = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b1;
  logic [23:0]                  m_axis_tdata;
  logic                         m_axis_tuser;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [gmaf_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [gmaf_pkg::DistW-1:0]   cfg_data_i = '0;

  reading_t       pending_readings[$];
  filter_result_t expected_results[$];
  reading_t       reading_in_flight;
  idle_mode_e     idle_mode = IDLE_NONE;
  int unsigned    fail_count = 0;
  int unsigned    cycle_count = 0;
  logic [gmaf_pkg::ChanW-1:0] last_channel = '0;

  logic [gmaf_pkg::DistW-1:0] max_distance;
  logic [gmaf_pkg::DistW-1:0] bad_code;
  logic [gmaf_pkg::DistW-1:0] ring[NumChannels][TapCount];
  logic [SumW-1:0]            ring_sum[NumChannels];
  logic [PosW-1:0]            ring_pos[NumChannels];
  logic [gmaf_pkg::DistW-1:0] channel_avg[NumChannels];

  gated_moving_average_filter #(
    .WINDOW_SIZE  (TapCount),
    .CHANNEL_COUNT(NumChannels)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  function automatic filter_result_t filter_reading(reading_t r);
    filter_result_t res;
    logic [PosW-1:0] pos;
    res.out_channel = r.channel;
    res.average     = '0;
    res.accepted    = 1'b0;
    if (r.channel < NumChannels) begin
      if (r.distance != bad_code && r.distance <= max_distance) begin
        pos = ring_pos[r.channel];
        ring_sum[r.channel] = ring_sum[r.channel] - ring[r.channel][pos] + r.distance;
        ring[r.channel][pos] = r.distance;
        ring_pos[r.channel] = (pos == TapCount - 1) ? '0 : pos + 1'b1;
        channel_avg[r.channel] = gmaf_pkg::DistW'(ring_sum[r.channel] / TapCount);
        res.accepted = 1'b1;
      end
      res.average = channel_avg[r.channel];
    end
    return res;
  endfunction

  function automatic bit chance(int unsigned percent);
    return $urandom_range(99) < percent;
  endfunction

  function automatic bit sender_holds();
    case (idle_mode)
      IDLE_SEND: return chance(60);
      IDLE_BOTH: return chance(14);
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECV: return chance(60);
      IDLE_BOTH: return chance(14);
      default:   return 1'b0;
    endcase
  endfunction

  function automatic logic [gmaf_pkg::DistW-1:0] pick_distance();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 55) return gmaf_pkg::DistW'($urandom_range(max_distance, 0));
    if (sel < 63) return max_distance;
    if (sel < 70) return max_distance + 1'b1;
    if (sel < 78) return bad_code;
    if (sel < 83) return '0;
    if (sel < 88) return '1;
    return gmaf_pkg::DistW'($urandom);
  endfunction

  function automatic reading_t random_reading();
    reading_t r;
    if (chance(40)) r.channel = last_channel;
    else r.channel = gmaf_pkg::ChanW'($urandom_range(NumChannels - 1));
    last_channel = r.channel;
    r.distance = pick_distance();
    return r;
  endfunction

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(filter_reading(reading_in_flight));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_readings.size() > 0 && !sender_holds()) begin
          reading_in_flight = pending_readings.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'd0, reading_in_flight.distance, reading_in_flight.channel};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    filter_result_t exp_res;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
          fail_count++;
        end else begin
          exp_res = expected_results.pop_front();
          if (m_axis_tdata[1:0] !== exp_res.out_channel) begin
            $error("out_channel expected %0d actual %0d", exp_res.out_channel,
                   m_axis_tdata[1:0]);
            fail_count++;
          end
          if (m_axis_tdata[17:2] !== exp_res.average) begin
            $error("filtered_distance expected %0d actual %0d", exp_res.average,
                   m_axis_tdata[17:2]);
            fail_count++;
          end
          if (m_axis_tuser !== exp_res.accepted) begin
            $error("sample_accepted expected %0d actual %0d", exp_res.accepted,
                   m_axis_tuser);
            fail_count++;
          end
        end
      end
      m_axis_tready <= !receiver_stalls();
    end
  end

  task automatic write_register(logic [gmaf_pkg::CfgIdxW-1:0] idx,
                                logic [gmaf_pkg::DistW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == gmaf_pkg::CfgMaxDist) max_distance = value;
    else if (idx == gmaf_pkg::CfgInvCode) bad_code = value;
  endtask

  // sample at the falling edge so that all clocked updates have settled
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_readings.size() > 0 || s_axis_tvalid || expected_results.size() > 0);
  endtask

  task automatic push_reading(logic [gmaf_pkg::ChanW-1:0] ch,
                              logic [gmaf_pkg::DistW-1:0] value);
    reading_t r;
    r.channel  = ch;
    r.distance = value;
    pending_readings.push_back(r);
  endtask

  task automatic run_phase(idle_mode_e mode, int unsigned count);
    idle_mode = mode;
    repeat (count) pending_readings.push_back(random_reading());
    wait_drained();
  endtask

  initial begin
    max_distance = gmaf_pkg::FillValue;
    bad_code     = gmaf_pkg::InvalidReset;
    for (int c = 0; c < NumChannels; c++) begin
      for (int t = 0; t < TapCount; t++) ring[c][t] = gmaf_pkg::FillValue;
      ring_sum[c]    = SumW'(gmaf_pkg::FillValue * TapCount);
      ring_pos[c]    = '0;
      channel_avg[c] = gmaf_pkg::FillValue;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int c = 0; c < NumChannels; c++) begin
      push_reading(gmaf_pkg::ChanW'(c), gmaf_pkg::FillValue);
      push_reading(gmaf_pkg::ChanW'(c), gmaf_pkg::FillValue + 16'd1);
      push_reading(gmaf_pkg::ChanW'(c), gmaf_pkg::InvalidReset);
      push_reading(gmaf_pkg::ChanW'(c), 16'd0);
    end
    push_reading(2'd1, 16'd3999);
    push_reading(2'd1, 16'h5555);
    push_reading(2'd2, 16'h0AAA);
    push_reading(2'd3, 16'h0555);
    for (int t = 0; t < TapCount; t++) push_reading(2'd0, 16'd1);
    wait_drained();

    run_phase(IDLE_NONE, 250);

    write_register(gmaf_pkg::CfgMaxDist, 16'hFFFF);
    write_register(gmaf_pkg::CfgInvCode, 16'h0000);
    run_phase(IDLE_SEND, 250);

    write_register(gmaf_pkg::CfgMaxDist, 16'h0000);
    write_register(gmaf_pkg::CfgInvCode, 16'hFFFF);
    run_phase(IDLE_RECV, 200);

    write_register(gmaf_pkg::CfgMaxDist, 16'd20000);
    write_register(gmaf_pkg::CfgInvCode, 16'd1234);
    write_register(CfgUnmapped, 16'd0);
    write_register(CfgTopIndex, 16'd0);
    run_phase(IDLE_BOTH, 400);

    write_register(gmaf_pkg::CfgMaxDist, gmaf_pkg::FillValue);
    write_register(gmaf_pkg::CfgInvCode, gmaf_pkg::InvalidReset);
    run_phase(IDLE_SEND, 200);
    run_phase(IDLE_NONE, 200);

    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
